@@ src/aabb_pkg.sv @@
`default_nettype none

package aabb_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int COORD_BITS = 32;

  // fixed field widths of the channels
  localparam int FIELD_W = 32;
  localparam int SLOT_W  = 5;
  localparam int MASK_W  = 32;

  localparam int ROW_W  = $clog2(NUM_SLOTS);
  localparam int MASK_N = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic wr_box;
    logic rm_slot;
    logic clr_all;
    logic load_first;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] xl;
    logic [COORD_BITS-1:0] xh;
    logic [COORD_BITS-1:0] yl;
    logic [COORD_BITS-1:0] yh;
    logic [COORD_BITS-1:0] zl;
    logic [COORD_BITS-1:0] zh;
  } box_t;

endpackage

`default_nettype wire

@@ src/aabb_if.sv @@
`default_nettype none

interface aabb_in_if;
  import aabb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [SLOT_W-1:0]         slot_index;
  logic signed [FIELD_W-1:0] x_low;
  logic signed [FIELD_W-1:0] x_high;
  logic signed [FIELD_W-1:0] y_low;
  logic signed [FIELD_W-1:0] y_high;
  logic signed [FIELD_W-1:0] z_low;
  logic signed [FIELD_W-1:0] z_high;

  modport source (output valid, opcode, slot_index, x_low, x_high, y_low, y_high,
                  z_low, z_high, input ready);
  modport sink (input valid, opcode, slot_index, x_low, x_high, y_low, y_high,
                z_low, z_high, output ready);
endinterface

interface aabb_out_if;
  import aabb_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] row_slot;
  logic [MASK_W-1:0] overlap_mask;
  logic              last_row;

  modport source (output valid, row_slot, overlap_mask, last_row, input ready);
  modport sink (input valid, row_slot, overlap_mask, last_row, output ready);
endinterface

`default_nettype wire

@@ src/aabb_ctrl.sv @@
`default_nettype none

module aabb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    opcode_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output aabb_pkg::cmd_t     cmd_o,
  input  wire aabb_pkg::sts_t sts_i
);
  import aabb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic ov_q, ov_d;
  logic acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o = '0;
    if (acc) begin
      case (opcode_e'(opcode_i))
        OP_WRITE:  cmd_o.wr_box     = 1'b1;
        OP_REMOVE: cmd_o.rm_slot    = 1'b1;
        OP_SWEEP:  cmd_o.load_first = 1'b1;
        OP_CLEAR:  cmd_o.clr_all    = 1'b1;
        default:   cmd_o = '0;
      endcase
    end
    // a row moves out when the output register is free or being drained
    cmd_o.advance = (state_q == ST_EMIT) && (!ov_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_o.load_first) state_d = ST_EMIT;
      ST_EMIT: if (cmd_o.advance && sts_i.last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.advance) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

@@ src/aabb_dp.sv @@
`default_nettype none

module aabb_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire aabb_pkg::cmd_t                   cmd_i,
  output aabb_pkg::sts_t                        sts_o,
  input  wire logic [aabb_pkg::SLOT_W-1:0]      slot_index_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     x_low_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     x_high_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     y_low_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     y_high_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     z_low_i,
  input  wire logic [aabb_pkg::FIELD_W-1:0]     z_high_i,
  output logic [aabb_pkg::SLOT_W-1:0]           row_slot_o,
  output logic [aabb_pkg::MASK_W-1:0]           overlap_mask_o,
  output logic                                  last_row_o
);
  import aabb_pkg::*;

  function automatic logic span_meets(input logic [COORD_BITS-1:0] lo_a,
                                      input logic [COORD_BITS-1:0] hi_a,
                                      input logic [COORD_BITS-1:0] lo_b,
                                      input logic [COORD_BITS-1:0] hi_b);
    return !(($signed(lo_a) > $signed(hi_b)) || ($signed(hi_a) < $signed(lo_b)));
  endfunction

  logic [NUM_SLOTS-1:0] valid_q;
  box_t                 box_q [NUM_SLOTS];
  box_t                 row_q;
  logic [ROW_W-1:0]     cnt_q, cnt_d;
  logic [ROW_W-1:0]     wr_idx;
  logic                 idx_ok;
  logic                 last;
  logic [MASK_W-1:0]    mask;
  box_t                 wr_box;

  assign wr_idx = ROW_W'(slot_index_i);
  assign idx_ok = (int'(slot_index_i) < NUM_SLOTS);
  assign last   = (cnt_q == ROW_W'(NUM_SLOTS - 1));
  assign sts_o.last = last;

  assign wr_box.xl = x_low_i[COORD_BITS-1:0];
  assign wr_box.xh = x_high_i[COORD_BITS-1:0];
  assign wr_box.yl = y_low_i[COORD_BITS-1:0];
  assign wr_box.yh = y_high_i[COORD_BITS-1:0];
  assign wr_box.zl = z_low_i[COORD_BITS-1:0];
  assign wr_box.zh = z_high_i[COORD_BITS-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load_first) begin
      cnt_d = '0;
    end else if (cmd_i.advance && !last) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // one comparator lane per slot against the latched row box
  always_comb begin
    mask = '0;
    for (int j = 0; j < MASK_N; j++) begin
      mask[j] = valid_q[cnt_q] && valid_q[j] && (cnt_q != ROW_W'(j))
             && span_meets(row_q.xl, row_q.xh, box_q[j].xl, box_q[j].xh)
             && span_meets(row_q.yl, row_q.yh, box_q[j].yl, box_q[j].yh)
             && span_meets(row_q.zl, row_q.zh, box_q[j].zl, box_q[j].zh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr_box && idx_ok) begin
        valid_q[wr_idx] <= 1'b1;
      end else if (cmd_i.rm_slot && idx_ok) begin
        valid_q[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_box && idx_ok) begin
      box_q[wr_idx] <= wr_box;
    end
    if (cmd_i.load_first || (cmd_i.advance && !last)) begin
      row_q <= box_q[cnt_d];
    end
    if (cmd_i.advance) begin
      row_slot_o     <= SLOT_W'(cnt_q);
      overlap_mask_o <= mask;
      last_row_o     <= last;
    end
  end

endmodule

`default_nettype wire

@@ src/aabb_overlap_broad_phase.sv @@
// channel | dir | beat payload
// in_s    | in  | opcode, slot_index, x/y/z low and high
// out_m   | out | row_slot, overlap_mask, last_row
//
// write, remove and clear give no beat.
// a sweep latches the first row box, then moves one row a cycle through the
// per-slot comparator lanes into the output register while it is not stalled.
// input is taken only while no sweep runs; a stalled output holds the sweep.
// reset clears all valid bits at once; box contents are not reset.
`default_nettype none

module aabb_overlap_broad_phase (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aabb_in_if.sink   in_s,
  aabb_out_if.source out_m
);
  import aabb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  aabb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .opcode_i    (in_s.opcode),
    .in_ready_o  (in_s.ready),
    .out_ready_i (out_m.ready),
    .out_valid_o (out_m.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  aabb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .slot_index_i   (in_s.slot_index),
    .x_low_i        (in_s.x_low),
    .x_high_i       (in_s.x_high),
    .y_low_i        (in_s.y_low),
    .y_high_i       (in_s.y_high),
    .z_low_i        (in_s.z_low),
    .z_high_i       (in_s.z_high),
    .row_slot_o     (out_m.row_slot),
    .overlap_mask_o (out_m.overlap_mask),
    .last_row_o     (out_m.last_row)
  );

endmodule

`default_nettype wire

@@ dv/overlap_row_check.sv @@
`default_nettype none

module overlap_row_check (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aabb_in_if        in_w,
  aabb_out_if       out_w,
  output int        fail_count,
  output int        rows_pending
);
  import aabb_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask;
    logic              tail;
  } row_t;

  box_t held_box  [NUM_SLOTS];
  logic held_live [NUM_SLOTS];
  row_t rows_owed [$];
  int   misses = 0;

  // closed intervals, signed compare
  function automatic logic spans_meet(input logic signed [COORD_BITS-1:0] lo_a, hi_a,
                                      input logic signed [COORD_BITS-1:0] lo_b, hi_b);
    return !(lo_a > hi_b || hi_a < lo_b);
  endfunction

  function automatic logic boxes_touch(input box_t a, input box_t b);
    return spans_meet(a.xl, a.xh, b.xl, b.xh) && spans_meet(a.yl, a.yh, b.yl, b.yh) &&
           spans_meet(a.zl, a.zh, b.zl, b.zh);
  endfunction

  function automatic void queue_sweep_rows();
    row_t r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      r.slot = i[SLOT_W-1:0];
      r.mask = '0;
      r.tail = (i == NUM_SLOTS - 1);
      if (held_live[i]) begin
        for (int j = 0; j < MASK_N; j++) begin
          if (j != i && held_live[j] && boxes_touch(held_box[i], held_box[j])) r.mask[j] = 1'b1;
        end
      end
      rows_owed = {rows_owed, r};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_t due;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) held_live[s] = 1'b0;
      rows_owed.delete();
    end else begin
      // rows leaving belong to an earlier sweep, so pop before predicting
      if (out_w.valid && out_w.ready) begin
        if (rows_owed.size() == 0) begin
          misses++;
          $display("%0t: unexpected row beat: expected none, got slot %0d mask %h last %b",
                   $time, out_w.row_slot, out_w.overlap_mask, out_w.last_row);
        end else begin
          due = rows_owed.pop_front();
          if (out_w.row_slot !== due.slot) begin
            misses++;
            $display("%0t: row_slot expected %0d, got %0d", $time, due.slot, out_w.row_slot);
          end
          if (out_w.overlap_mask !== due.mask) begin
            misses++;
            $display("%0t: overlap_mask of slot %0d expected %h, got %h",
                     $time, due.slot, due.mask, out_w.overlap_mask);
          end
          if (out_w.last_row !== due.tail) begin
            misses++;
            $display("%0t: last_row of slot %0d expected %b, got %b",
                     $time, due.slot, due.tail, out_w.last_row);
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        case (opcode_e'(in_w.opcode))
          OP_WRITE: begin
            if (in_w.slot_index < NUM_SLOTS) begin
              held_box[in_w.slot_index]  = {in_w.x_low, in_w.x_high, in_w.y_low, in_w.y_high,
                                            in_w.z_low, in_w.z_high};
              held_live[in_w.slot_index] = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (in_w.slot_index < NUM_SLOTS) held_live[in_w.slot_index] = 1'b0;
          end
          OP_CLEAR: begin
            for (int s = 0; s < NUM_SLOTS; s++) held_live[s] = 1'b0;
          end
          default: queue_sweep_rows();
        endcase
      end
    end
    fail_count   <= misses;
    rows_pending <= rows_owed.size();
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;
  import aabb_pkg::*;

  localparam int RAND_ITEMS  = 260;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;
  int   quiet = 0;
  int   fail_count;
  int   rows_pending;
  box_t recent = '0;

  aabb_in_if  in_w ();
  aabb_out_if out_w ();

  aabb_overlap_broad_phase uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_w),
    .out_m (out_w)
  );

  overlap_row_check row_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w),
    .out_w       (out_w),
    .fail_count  (fail_count),
    .rows_pending(rows_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_w.ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one axis: mostly small spans near the origin, some touching or just missing
  // the last written box, some inverted, some anywhere in the full range
  function automatic logic [63:0] rand_span(input logic [COORD_BITS-1:0] near);
    logic [COORD_BITS-1:0] lo, hi;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      lo = $urandom;
      hi = $urandom;
    end else if (pick < 30) begin
      lo = near;
      hi = near + $urandom_range(64);
    end else if (pick < 38) begin
      lo = near + 1;
      hi = lo + $urandom_range(64);
    end else if (pick < 43) begin
      hi = $urandom_range(200) - 100;
      lo = hi + 1 + $urandom_range(20);
    end else begin
      lo = $urandom_range(400) - 200;
      hi = lo + $urandom_range(120);
    end
    return {lo, hi};
  endfunction

  function automatic box_t rand_box();
    return {rand_span(recent.xh), rand_span(recent.yh), rand_span(recent.zh)};
  endfunction

  task automatic send_beat(input opcode_e op, input logic [SLOT_W-1:0] slot, input box_t b);
    while (!calm && $urandom_range(99) < 24) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.opcode     <= op;
    in_w.slot_index <= slot;
    in_w.x_low      <= b.xl;
    in_w.x_high     <= b.xh;
    in_w.y_low      <= b.yl;
    in_w.y_high     <= b.yh;
    in_w.z_low      <= b.zl;
    in_w.z_high     <= b.zh;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    if (op == OP_WRITE) recent = b;
  endtask

  initial begin
    box_t        b;
    int unsigned pick;
    in_w.valid      = 1'b0;
    in_w.opcode     = OP_SWEEP;
    in_w.slot_index = '0;
    in_w.x_low      = '0;
    in_w.x_high     = '0;
    in_w.y_low      = '0;
    in_w.y_high     = '0;
    in_w.z_low      = '0;
    in_w.z_high     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: every row comes back with no bits
    send_beat(OP_SWEEP, 5'd9, rand_box());
    // largest possible box
    send_beat(OP_WRITE, 5'd0, {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 32'h7fff_ffff});
    send_beat(OP_WRITE, 5'd1, '0);
    // touches the point box at x = 0
    send_beat(OP_WRITE, 5'd2, {32'h0000_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0000_0001,
                               32'hffff_ffff, 32'h0000_0001});
    // misses the point box by one lsb on y
    send_beat(OP_WRITE, 5'd3, {32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0005,
                               32'hffff_ffff, 32'h0000_0001});
    // inverted on x
    send_beat(OP_WRITE, 5'd31, {32'h0000_000a, 32'hffff_fff6, 32'hffff_ff00, 32'h0000_0100,
                                32'hffff_ff00, 32'h0000_0100});
    send_beat(OP_WRITE, 5'd30, {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff});
    send_beat(OP_WRITE, 5'd29, {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000});
    send_beat(OP_SWEEP, 5'd31, rand_box());
    // update a live slot
    send_beat(OP_WRITE, 5'd1, {32'hffff_fffb, 32'hffff_ffff, 64'd0, 64'd0});
    send_beat(OP_REMOVE, 5'd2, rand_box());
    // remove of a slot that was never written
    send_beat(OP_REMOVE, 5'd5, rand_box());
    send_beat(OP_SWEEP, 5'd0, rand_box());
    send_beat(OP_CLEAR, 5'd17, rand_box());
    send_beat(OP_SWEEP, 5'd22, rand_box());
    send_beat(OP_WRITE, 5'd7, {6{32'hffff_ffff}});
    send_beat(OP_WRITE, 5'd8, {3{32'haaaa_aaaa, 32'h5555_5555}});
    send_beat(OP_SWEEP, 5'd7, rand_box());

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 110 && n < 170);
      pick = $urandom_range(99);
      b    = rand_box();
      if (pick < 58) send_beat(OP_WRITE, SLOT_W'($urandom_range(31)), b);
      else if (pick < 74) send_beat(OP_REMOVE, SLOT_W'($urandom_range(31)), b);
      else if (pick < 96) send_beat(OP_SWEEP, SLOT_W'($urandom_range(31)), b);
      else send_beat(OP_CLEAR, SLOT_W'($urandom_range(31)), b);
    end
    calm = 1'b0;
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
